@@ hw/rtl/ppm_frame_decoder_defines.svh @@
// Assertion macros for the PPM frame decoder.
// No dependencies; included by modules that carry assertions.
`ifndef PPM_FRAME_DECODER_DEFINES_SVH
`define PPM_FRAME_DECODER_DEFINES_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define PPMFD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ppm_frame_decoder: check failed");
// condition must never be seen outside reset
`define PPMFD_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("ppm_frame_decoder: forbidden condition seen");
`else
`define PPMFD_ASSERT(label, clk, rst, prop)
`define PPMFD_NEVER(label, clk, rst, cond)
`endif

`endif

@@ hw/rtl/ppmfd_pkg.sv @@
// Shared types, constants and helpers for the PPM frame decoder.
// No dependencies.
package ppmfd_pkg;

   localparam int TIME_W  = 16;
   localparam int QUAL_W  = 8;
   localparam int CHIDX_W = 4;
   localparam int GRADE_W = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [QUAL_W-1:0] QUALITY_MAX  = 8'd200;
   localparam logic [QUAL_W-1:0] QUALITY_STEP = 8'd4;
   localparam logic [QUAL_W-1:0] GRADE_GOOD_Q = 8'd160;
   localparam logic [QUAL_W-1:0] GRADE_OK_Q   = 8'd140;
   localparam logic [QUAL_W-1:0] GRADE_BAD_Q  = 8'd120;

   localparam logic [GRADE_W-1:0] GRADE_LOST = 2'd0;
   localparam logic [GRADE_W-1:0] GRADE_BAD  = 2'd1;
   localparam logic [GRADE_W-1:0] GRADE_OK   = 2'd2;
   localparam logic [GRADE_W-1:0] GRADE_GOOD = 2'd3;

   localparam logic KIND_EDGE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_SYNC_GAP  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_WIDTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_WIDTH = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER    = 2'd3;

   localparam logic [TIME_W-1:0] SYNC_GAP_RST  = 16'd8750;
   localparam logic [TIME_W-1:0] MIN_WIDTH_RST = 16'd2000;
   localparam logic [TIME_W-1:0] MAX_WIDTH_RST = 16'd5500;
   localparam logic [TIME_W-1:0] CENTER_RST    = 16'd3750;

   typedef struct packed {
      logic [TIME_W-1:0] sync_gap;
      logic [TIME_W-1:0] min_width;
      logic [TIME_W-1:0] max_width;
      logic [TIME_W-1:0] center;
   } csr_type;

   // per-channel state held in one cell; raw of zero means empty
   typedef struct packed {
      logic [TIME_W-1:0] raw;
      logic [TIME_W-1:0] pos;
      logic [TIME_W-1:0] chg;
   } chan_type;

   function automatic logic [GRADE_W-1:0] grade_of(input logic [QUAL_W-1:0] q);
      logic [GRADE_W-1:0] g;
      priority if (q >= GRADE_GOOD_Q) g = GRADE_GOOD;
      else if (q >= GRADE_OK_Q)       g = GRADE_OK;
      else if (q >= GRADE_BAD_Q)      g = GRADE_BAD;
      else                            g = GRADE_LOST;
      return g;
   endfunction

endpackage

@@ hw/rtl/ppmfd_cell.sv @@
// One channel cell of the decoder ring: raw width, position and change.
// Depends on ppmfd_pkg.
module ppmfd_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     shift_en,
   input  logic                     load_en,
   input  logic [ppmfd_pkg::TIME_W-1:0] load_raw,
   input  ppmfd_pkg::chan_type      nbr_in,
   output ppmfd_pkg::chan_type      chan_out
);

   ppmfd_pkg::chan_type chan_ff, chan_in;

   always_comb begin
      chan_in = chan_ff;
      if (shift_en) begin
         chan_in = nbr_in;
      end else if (load_en) begin
         chan_in.raw = load_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff <= '0;
      end else begin
         chan_ff <= chan_in;
      end
   end

   assign chan_out = chan_ff;

endmodule

@@ hw/rtl/ppmfd_proc.sv @@
// Head-of-ring update: consumes a channel's raw width and, if it is in range, refreshes position.
// Depends on ppmfd_pkg.
module ppmfd_proc (
   input  ppmfd_pkg::chan_type head_in,
   input  ppmfd_pkg::csr_type  csr,
   output ppmfd_pkg::chan_type head_out,
   output logic                updated
);

   logic                         in_range;
   logic [ppmfd_pkg::TIME_W-1:0] new_pos;

   always_comb begin
      in_range = (head_in.raw >= csr.min_width) && (head_in.raw < csr.max_width);
      updated  = (head_in.raw != '0) && in_range;
      new_pos  = head_in.raw - csr.center;
      head_out = head_in;
      head_out.raw = '0;
      if (updated) begin
         head_out.pos = new_pos;
         head_out.chg = new_pos - head_in.pos;
      end
   end

endmodule

@@ hw/rtl/ppm_frame_decoder.sv @@
// PPM frame decoder: edge capture in, one result per channel on each tick.
// req_* carries a transaction of kind (0 capture edge, 1 processing tick)
// and capture_time. An edge is absorbed in the cycle it is accepted and
// gives no result. A tick lowers link quality and then rotates the ring of
// NUM_CHANNELS channel cells once round, one channel per cycle unless the
// output stalls: the cell at the head is updated and re-enters at the tail,
// and its result goes to the rsp_* output register once the tick has set
// busy; the last carries rsp_last. req_stall is high while a tick is being
// walked. rsp_stall freezes the output register and the ring; nothing is
// dropped. csr_* writes the four timing registers; the user is to use it
// only while the block is idle, which the block itself does not enforce.
// Synchronous reset clears all channel state, edge time, channel count and
// link quality and restores register defaults.
// Depends on ppmfd_pkg, ppmfd_cell, ppmfd_proc and the defines header.
`include "ppm_frame_decoder_defines.svh"

module ppm_frame_decoder #(
   parameter int NUM_CHANNELS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_kind,
   input  logic [ppmfd_pkg::TIME_W-1:0]          req_capture_time,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [ppmfd_pkg::CHIDX_W-1:0]         rsp_channel_index,
   output logic signed [ppmfd_pkg::TIME_W-1:0]   rsp_position,
   output logic signed [ppmfd_pkg::TIME_W-1:0]   rsp_change,
   output logic                                  rsp_updated,
   output logic [ppmfd_pkg::GRADE_W-1:0]         rsp_quality_grade,
   output logic                                  rsp_last,
   input  logic                                  csr_wr_en,
   input  logic [ppmfd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ppmfd_pkg::TIME_W-1:0]          csr_wdata
);

   localparam int CNT_W = $clog2(NUM_CHANNELS + 1);
   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   ppmfd_pkg::csr_type csr_ff, csr_in;

   logic [ppmfd_pkg::TIME_W-1:0] prev_edge_ff, prev_edge_in;
   logic [CNT_W-1:0]             next_ch_ff, next_ch_in;
   logic [ppmfd_pkg::QUAL_W-1:0] quality_ff, quality_in;
   logic                         busy_ff, busy_in;
   logic [IDX_W-1:0]             cnt_ff, cnt_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   logic [ppmfd_pkg::CHIDX_W-1:0] rsp_idx_ff;
   logic [ppmfd_pkg::TIME_W-1:0]  rsp_pos_ff, rsp_chg_ff;
   logic                          rsp_upd_ff, rsp_last_ff;
   logic [ppmfd_pkg::GRADE_W-1:0] rsp_grade_ff;

   logic                         req_acc, edge_acc, tick_acc, store, sync_hit;
   logic                         advance, cnt_last, head_upd;
   logic [ppmfd_pkg::TIME_W-1:0] interval;

   ppmfd_pkg::chan_type cell_q [NUM_CHANNELS];
   ppmfd_pkg::chan_type head_nxt;

   // ---------------- control ----------------
   assign req_stall = busy_ff;
   assign req_acc   = req_valid & ~busy_ff;
   assign edge_acc  = req_acc & (req_kind == ppmfd_pkg::KIND_EDGE);
   assign tick_acc  = req_acc & (req_kind == ppmfd_pkg::KIND_TICK);
   assign interval  = req_capture_time - prev_edge_ff;
   assign sync_hit  = interval > csr_ff.sync_gap;
   assign store     = edge_acc & ~sync_hit & (next_ch_ff < CNT_W'(NUM_CHANNELS));
   assign advance   = busy_ff & (~rsp_valid_ff | ~rsp_stall);
   assign cnt_last  = cnt_ff == IDX_W'(NUM_CHANNELS - 1);

   always_comb begin
      csr_in = csr_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            ppmfd_pkg::REG_SYNC_GAP:  csr_in.sync_gap  = csr_wdata;
            ppmfd_pkg::REG_MIN_WIDTH: csr_in.min_width = csr_wdata;
            ppmfd_pkg::REG_MAX_WIDTH: csr_in.max_width = csr_wdata;
            ppmfd_pkg::REG_CENTER:    csr_in.center    = csr_wdata;
         endcase
      end
   end

   always_comb begin
      prev_edge_in = prev_edge_ff;
      next_ch_in   = next_ch_ff;
      quality_in   = quality_ff;
      busy_in      = busy_ff;
      cnt_in       = cnt_ff;
      if (edge_acc) begin
         prev_edge_in = req_capture_time;
         if (sync_hit) begin
            next_ch_in = '0;
         end else if (store) begin
            next_ch_in = next_ch_ff + CNT_W'(1);
            if (quality_ff <= ppmfd_pkg::QUALITY_MAX - ppmfd_pkg::QUALITY_STEP) begin
               quality_in = quality_ff + ppmfd_pkg::QUALITY_STEP;
            end else begin
               quality_in = ppmfd_pkg::QUALITY_MAX;
            end
         end
      end
      if (tick_acc) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         if (quality_ff != '0) begin
            quality_in = quality_ff - 8'd1;
         end
      end else if (advance) begin
         cnt_in = cnt_ff + IDX_W'(1);
         if (cnt_last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.sync_gap  <= ppmfd_pkg::SYNC_GAP_RST;
         csr_ff.min_width <= ppmfd_pkg::MIN_WIDTH_RST;
         csr_ff.max_width <= ppmfd_pkg::MAX_WIDTH_RST;
         csr_ff.center    <= ppmfd_pkg::CENTER_RST;
         prev_edge_ff     <= '0;
         next_ch_ff       <= '0;
         quality_ff       <= '0;
         busy_ff          <= 1'b0;
         cnt_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         csr_ff       <= csr_in;
         prev_edge_ff <= prev_edge_in;
         next_ch_ff   <= next_ch_in;
         quality_ff   <= quality_in;
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------- channel ring ----------------
   // tail takes the updated head, so one full turn restores the alignment
   generate
      for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_cell
         ppmfd_pkg::chan_type nbr;
         if (i == NUM_CHANNELS - 1) begin : g_tail
            assign nbr = head_nxt;
         end else begin : g_mid
            assign nbr = cell_q[i+1];
         end
         ppmfd_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (advance),
            .load_en  (store && (next_ch_ff == CNT_W'(i))),
            .load_raw (interval),
            .nbr_in   (nbr),
            .chan_out (cell_q[i])
         );
      end
   endgenerate

   ppmfd_proc u_proc (
      .head_in  (cell_q[0]),
      .csr      (csr_ff),
      .head_out (head_nxt),
      .updated  (head_upd)
   );

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_idx_ff   <= ppmfd_pkg::CHIDX_W'(cnt_ff);
         rsp_pos_ff   <= head_nxt.pos;
         rsp_chg_ff   <= head_nxt.chg;
         rsp_upd_ff   <= head_upd;
         rsp_grade_ff <= ppmfd_pkg::grade_of(quality_ff);
         rsp_last_ff  <= cnt_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_channel_index = rsp_idx_ff;
   assign rsp_position      = rsp_pos_ff;
   assign rsp_change        = rsp_chg_ff;
   assign rsp_updated       = rsp_upd_ff;
   assign rsp_quality_grade = rsp_grade_ff;
   assign rsp_last          = rsp_last_ff;

   // ---------------- checks ----------------
   `PPMFD_ASSERT(a_tick_starts_walk, clock, reset, tick_acc |=> busy_ff)
   `PPMFD_ASSERT(a_quality_frozen_in_walk, clock, reset, busy_ff |=> $stable(quality_ff))
   `PPMFD_ASSERT(a_rsp_held_on_stall, clock, reset, rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_idx_ff))
   `PPMFD_NEVER(a_channel_count_range, clock, reset, next_ch_ff > CNT_W'(NUM_CHANNELS))

endmodule
